@@ rtl/lpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lpr_pkg;
    localparam int MAX_FRAMES = 16;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int ADDR_W     = 31;
    localparam int PS_W       = 17;
    localparam int FR_W       = 5;
    localparam int FAULT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES   = 2'd1;
endpackage
`default_nettype wire

@@ rtl/lpr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/lpr_rem.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lpr_rem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [lpr_pkg::ADDR_W-1:0] i_addr,
    input  wire logic [lpr_pkg::PS_W-1:0]   i_ps,
    output logic                            o_done,
    output logic      [lpr_pkg::PS_W-1:0]   o_rem
);
    import lpr_pkg::*;

    // restoring division, one quotient bit per cycle, remainder only
    logic [ADDR_W-1:0] r_addr;
    logic [PS_W-1:0]   r_ps;
    logic [PS_W:0]     r_rem;
    logic [4:0]        r_bit;
    logic              r_run;
    logic [PS_W:0]     n_trial;
    logic [PS_W:0]     n_rem;

    always_comb begin
        n_trial = {r_rem[PS_W-1:0], r_addr[r_bit]};
        if (n_trial >= {1'b0, r_ps}) begin
            n_rem = n_trial - {1'b0, r_ps};
        end else begin
            n_rem = n_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_addr <= i_addr;
                r_ps   <= i_ps;
                r_rem  <= '0;
                r_bit  <= 5'(ADDR_W - 1);
            end else if (r_run) begin
                r_rem <= n_rem;
                if (r_bit == 5'd0) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_bit <= r_bit - 5'd1;
                end
            end
        end
    end

    assign o_rem = r_rem[PS_W-1:0];
endmodule
`default_nettype wire

@@ rtl/lru_page_replacement.sv @@
`timescale 1ns / 1ps
`default_nettype none
// lru page replacement tracker
// request channel: drive i_address and raise start; the request is taken at
//   a rising edge where start is high and busy is low. busy stays high until
//   the result has been shown.
// result channel: o_valid is high for exactly one cycle with o_hit,
//   o_page_base and o_fault_count; the receiver cannot stall, so the result
//   must be taken in that cycle.
// configuration: i_cfg_we with i_cfg_idx / i_cfg_data writes the page size (0)
//   or frames_in_use (1); other indexes are ignored. write only
//   while busy is low.
// sequence: the bit-serial remainder (launch, 31 bit steps, done), a read
//   and a compare per resident entry searched plus one more read on a miss,
//   a read and a write per entry moved, then the plan, last shift check and
//   append steps. one request at a time: none is taken while busy is high.
//   the remainder loop and the entry-by-entry search and shift through the
//   page ram bound the request rate.
// reset: synchronous active low; the resident set and fault count are
//   cleared, the page size returns to 4096 and frames_in_use to 16. the page
//   ram itself needs no clearing, only entries below the resident count are read.
module lru_page_replacement (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [lpr_pkg::ADDR_W-1:0]     i_address,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic      [lpr_pkg::ADDR_W-1:0]     o_page_base,
    output logic      [lpr_pkg::FAULT_W-1:0]    o_fault_count,
    input  wire logic                           i_cfg_we,
    input  wire logic [lpr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lpr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lpr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_SRCH_RD, ST_SRCH_CMP, ST_PLAN,
        ST_SH_RD, ST_SH_WR, ST_APPEND
    } t_state;

    t_state             r_state;
    logic [PS_W-1:0]    r_page_len;
    logic [FR_W-1:0]    r_frames;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_base;
    logic [CNT_W-1:0]   r_count;
    logic [FAULT_W-1:0] r_faults;
    logic [CNT_W-1:0]   r_idx;   // search index
    logic [CNT_W-1:0]   r_src;   // shift source
    logic [CNT_W-1:0]   r_dst;   // shift destination
    logic [CNT_W-1:0]   r_sh;    // entries removed before append
    logic               r_found;
    logic               r_div_go;

    logic               n_accept;
    logic               w_div_done;
    logic [PS_W-1:0]    w_rem;
    logic [ADDR_W-1:0]  w_rdata;
    logic               n_we;
    logic [IDX_W-1:0]   n_waddr;
    logic [ADDR_W-1:0]  n_wdata;
    logic [IDX_W-1:0]   n_raddr;
    logic [CNT_W-1:0]   n_lim;
    logic [CNT_W-1:0]   n_evict;
    logic [CNT_W-1:0]   n_wpos;

    assign busy     = (r_state != ST_IDLE);
    assign n_accept = start && !busy;

    // effective frame limit: zero means one, clamp at the ram depth
    always_comb begin
        if (r_frames == '0) begin
            n_lim = CNT_W'(1);
        end else if (CNT_W'(r_frames) > CNT_W'(MAX_FRAMES)) begin
            n_lim = CNT_W'(MAX_FRAMES);
        end else begin
            n_lim = CNT_W'(r_frames);
        end
        // on a miss, drop from the lru end until one slot below the limit
        if (r_count >= n_lim) begin
            n_evict = r_count - n_lim + CNT_W'(1);
        end else begin
            n_evict = '0;
        end
        n_wpos = r_count - r_sh;
    end

    // page ram port control
    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_dst[IDX_W-1:0];
        n_wdata = w_rdata;
        n_raddr = r_idx[IDX_W-1:0];
        case (r_state)
            ST_SH_RD: begin
                n_raddr = r_src[IDX_W-1:0];
            end
            ST_SH_WR: begin
                n_we = 1'b1;
            end
            ST_APPEND: begin
                n_we    = 1'b1;
                n_waddr = n_wpos[IDX_W-1:0];
                n_wdata = r_base;
            end
            default: begin
            end
        endcase
    end

    lpr_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_addr  (r_addr),
        .i_ps    (r_page_len),
        .o_done  (w_div_done),
        .o_rem   (w_rem)
    );

    lpr_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_FRAMES)
    ) u_pages (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_page_len <= PS_W'(4096);
            r_frames   <= FR_W'(16);
            r_count    <= '0;
            r_faults   <= '0;
            r_div_go   <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_div_go <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PAGE_LEN) begin
                    r_page_len <= i_cfg_data[PS_W-1:0];
                end else if (i_cfg_idx == CFG_FRAMES) begin
                    r_frames <= i_cfg_data[FR_W-1:0];
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_addr   <= i_address;
                        r_div_go <= 1'b1;
                        r_state  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        // zero page size leaves the address as is
                        if (r_page_len == '0) begin
                            r_base <= r_addr;
                        end else begin
                            r_base <= r_addr - ADDR_W'(w_rem);
                        end
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_state <= ST_SRCH_RD;
                    end
                end
                ST_SRCH_RD: begin
                    if (r_idx >= r_count) begin
                        r_state <= ST_PLAN;
                    end else begin
                        r_state <= ST_SRCH_CMP;
                    end
                end
                ST_SRCH_CMP: begin
                    if (w_rdata == r_base) begin
                        r_found <= 1'b1;
                        r_state <= ST_PLAN;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= ST_SRCH_RD;
                    end
                end
                ST_PLAN: begin
                    // hit: close the gap at the hit slot; miss: drop lru entries
                    if (r_found) begin
                        r_dst <= r_idx;
                        r_src <= r_idx + CNT_W'(1);
                        r_sh  <= CNT_W'(1);
                    end else begin
                        r_dst <= '0;
                        r_src <= n_evict;
                        r_sh  <= n_evict;
                        if (r_faults != '1) begin
                            r_faults <= r_faults + FAULT_W'(1);
                        end
                    end
                    r_state <= ST_SH_RD;
                end
                ST_SH_RD: begin
                    if (r_sh == '0 || r_src >= r_count) begin
                        r_state <= ST_APPEND;
                    end else begin
                        r_state <= ST_SH_WR;
                    end
                end
                ST_SH_WR: begin
                    r_src   <= r_src + CNT_W'(1);
                    r_dst   <= r_dst + CNT_W'(1);
                    r_state <= ST_SH_RD;
                end
                ST_APPEND: begin
                    if (!r_found) begin
                        r_count <= n_wpos + CNT_W'(1);
                    end
                    o_valid       <= 1'b1;
                    o_hit         <= r_found;
                    o_page_base   <= r_base;
                    o_fault_count <= r_faults;
                    r_state       <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
